// File: src/assert_macros.svh
// assertion helpers shared by the rtl files
// every user has i_clk and i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/lss_pkg.sv
package lss_pkg;

    // sketch geometry
    localparam int CPR    = 32;
    localparam int ROWS   = 8;
    localparam int NCELLS = ROWS * CPR;
    localparam int IDXW   = $clog2(NCELLS);
    localparam int RW     = ($clog2(ROWS + 1) > 4) ? $clog2(ROWS + 1) : 4;
    localparam int PW     = $clog2(CPR + 1);

    // modulus 2^62-57 and hash constants
    localparam logic [63:0] PRIME     = 64'd4611686018427387847;
    localparam logic [63:0] C_K1      = 64'h87c37b91114253d5;
    localparam logic [63:0] C_K2      = 64'h4cf5ad432745937f;
    localparam logic [63:0] C_M1      = 64'hff51afd7ed558ccd;
    localparam logic [63:0] C_M2      = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] SEED_SALT = 64'd123;
    localparam int          ROT_K     = 31;
    localparam int          SHR_M     = 33;

    typedef enum logic [1:0] {
        OP_UPDATE  = 2'd0,
        OP_RECOVER = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [63:0] item_key;
        logic signed [63:0] weight_delta;
        logic [3:0]         first_row;
        logic [3:0]         end_row;
    } t_in;

    typedef struct packed {
        logic               found;
        logic signed [63:0] recovered_key;
    } t_out;

    typedef enum logic [1:0] {
        AOP_MUL,
        AOP_MODMUL,
        AOP_DIV
    } t_aop;

    typedef struct packed {
        logic        start;
        t_aop        op;
        logic [63:0] a;
        logic [63:0] b;
    } t_areq;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_arsp;

    // a + b mod P for operands below P
    function automatic logic [61:0] f_add_mod(input logic [61:0] a, input logic [61:0] b);
        logic [62:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= PRIME[62:0]) begin
            s = s - PRIME[62:0];
        end
        return s[61:0];
    endfunction

endpackage

// File: src/lss_front.sv
module lss_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  lss_pkg::t_in  i_item,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [63:0]   i_cfg_data,
    output logic [63:0]   o_seed,
    output lss_pkg::t_in  o_cmd,
    output logic          o_cmd_vld,
    input  logic          i_cmd_pop
);
    import lss_pkg::*;

    logic [63:0] r_seed;
    t_in         r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        w_acc, w_enq, w_deq;

    // accept and classify: unused op code is taken and dropped
    assign o_full      = (r_cnt == 2'd2);
    assign w_acc       = i_push && !o_full;
    assign w_enq       = w_acc && (i_item.op != OP_NOP);
    assign w_deq       = i_cmd_pop && (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign o_cmd_vld   = (r_cnt != 2'd0);
    assign o_cfg_ready = 1'b1;
    assign o_seed      = r_seed;

    // seed register and two-entry command queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_seed <= i_cfg_data;
            end
            if (w_enq) begin
                r_q[r_wp] <= i_item;
                r_wp      <= !r_wp;
            end
            if (w_deq) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_enq} - {1'b0, w_deq};
        end
    end

endmodule

// File: src/lss_arith.sv
module lss_arith (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lss_pkg::t_areq i_req,
    output lss_pkg::t_arsp o_rsp
);
    import lss_pkg::*;

    `include "assert_macros.svh"

    localparam logic [6:0] MUL_STEPS = 7'd4;
    localparam logic [6:0] MM_STEPS  = 7'd62;
    localparam logic [6:0] DIV_STEPS = 7'd64;

    logic        r_busy, r_done;
    t_aop        r_op;
    logic [63:0] r_a, r_b, r_acc, r_res;
    logic [64:0] r_rem;
    logic [6:0]  r_cnt;

    logic [79:0] w_prod;
    logic [61:0] w_dbl, w_mm;
    logic [64:0] w_rs, w_rem;
    logic        w_qbit;
    logic [63:0] w_acc;

    // 64x16 partial product for the low-word multiply
    assign w_prod = {16'b0, r_a} * {64'b0, r_b[15:0]};

    // one step of multiply, modular double-and-add or restoring divide
    always_comb begin
        w_dbl  = f_add_mod(r_acc[61:0], r_acc[61:0]);
        w_mm   = r_b[61] ? f_add_mod(w_dbl, r_a[61:0]) : w_dbl;
        w_rs   = {r_rem[63:0], r_acc[63]};
        w_qbit = (w_rs >= {1'b0, r_b});
        w_rem  = w_qbit ? (w_rs - {1'b0, r_b}) : w_rs;
        case (r_op)
            AOP_MUL:    w_acc = r_acc + w_prod[63:0];
            AOP_MODMUL: w_acc = {2'b00, w_mm};
            AOP_DIV:    w_acc = {r_acc[62:0], w_qbit};
            default:    w_acc = r_acc;
        endcase
    end

    // operand latch and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_acc  <= (i_req.op == AOP_DIV) ? i_req.a : '0;
                r_rem  <= '0;
                case (i_req.op)
                    AOP_MUL:    r_cnt <= MUL_STEPS;
                    AOP_MODMUL: r_cnt <= MM_STEPS;
                    default:    r_cnt <= DIV_STEPS;
                endcase
            end else if (r_busy) begin
                r_acc <= w_acc;
                r_rem <= w_rem;
                if (r_op == AOP_MUL) begin
                    r_a <= r_a << 16;
                    r_b <= r_b >> 16;
                end else if (r_op == AOP_MODMUL) begin
                    r_b <= r_b << 1;
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= w_acc;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

    `ASSERT_IMP(a_start_idle, i_req.start, !r_busy)
    `ASSERT_NXT(a_done_pulse, r_done, !r_done)

endmodule

// File: src/lss_back.sv
module lss_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lss_pkg::t_in   i_cmd,
    input  logic           i_cmd_vld,
    output logic           o_cmd_pop,
    input  logic [63:0]    i_seed,
    output lss_pkg::t_areq o_areq,
    input  lss_pkg::t_arsp i_arsp,
    output lss_pkg::t_out  o_res,
    output logic           o_empty,
    input  logic           i_pop
);
    import lss_pkg::*;

    `include "assert_macros.svh"

    localparam int MW = 64 + 64 + 62;

    typedef enum logic [4:0] {
        S_IDLE, S_SEED, S_DK, S_ROW, S_LEVEL, S_UZ, S_UWR,
        S_RSTART, S_RCELL, S_RREAD, S_RCHK, S_RDIV, S_RZ, S_RCMP, S_RNEXT, S_RES,
        S_HK1, S_HK2, S_HA1, S_HA2, S_HB1, S_HB2,
        S_FZRED, S_FMUL, S_FSQ, S_FCM, S_FCRED, S_FFIN
    } t_state;

    function automatic logic [63:0] f_mix(input logic [63:0] x);
        return x ^ (x >> SHR_M);
    endfunction

    // leading zeros within the row's low bits, all-zero taken as one
    function automatic logic [PW-1:0] f_lz(input logic [CPR-1:0] v);
        logic [PW-1:0] p;
        p = PW'(CPR - 1);
        for (int i = 0; i < CPR; i++) begin
            if (v[i]) begin
                p = PW'(CPR - 1 - i);
            end
        end
        return p;
    endfunction

    function automatic logic [IDXW-1:0] f_idx(input logic [RW-1:0] row, input logic [PW-1:0] pos);
        return IDXW'(row) * IDXW'(CPR) + IDXW'(pos);
    endfunction

    t_state          r_state, r_hret, r_fret;
    logic            r_wait;
    logic [1:0]      r_op;
    logic [63:0]     r_key, r_delta, r_dk, r_s, r_h;
    logic [3:0]      r_first, r_end;
    logic [RW-1:0]   r_row, r_rend;
    logic [PW-1:0]   r_pos;
    logic [IDXW-1:0] r_idx;
    logic [63:0]     r_hd, r_hs, r_ht, r_ha, r_hb, r_hres;
    logic [63:0]     r_base, r_pw, r_e, r_c, r_cm, r_term;
    logic            r_cneg, r_qneg;
    logic [63:0]     r_un, r_ud, r_q;
    logic            r_found;
    logic [63:0]     r_rkey;

    logic [MW-1:0]   r_mem [NCELLS];
    logic            r_vld [NCELLS];
    logic [MW-1:0]   r_rd;
    logic            r_rdv;

    t_out            r_oq [2];
    logic            r_owp, r_orp;
    logic [1:0]      r_ocnt;

    logic            w_math, w_we, w_clr, w_res_push, w_res_pop;
    logic [63:0]     w_cnt, w_sum, w_k, w_a1, w_b1, w_res;
    logic [61:0]     w_fp;
    logic [PW-1:0]   w_lz;
    logic [RW-1:0]   w_end;
    t_areq           w_areq;

    // cell fields; an entry never written since clear reads as zero
    assign w_cnt = r_rdv ? r_rd[MW-1 -: 64] : '0;
    assign w_sum = r_rdv ? r_rd[125:62] : '0;
    assign w_fp  = r_rdv ? r_rd[61:0] : '0;

    // hash helpers on the arithmetic result
    assign w_res = i_arsp.res;
    assign w_k   = (w_res << ROT_K) | (w_res >> (64 - ROT_K));
    assign w_a1  = (r_hs ^ w_res ^ 64'd8) + (r_hs ^ 64'd8);
    assign w_b1  = (r_hs ^ 64'd8) + w_a1;
    assign w_lz  = f_lz((r_hres[CPR-1:0] == '0) ? CPR'(1) : r_hres[CPR-1:0]);
    assign w_end = (RW'(r_end) > RW'(ROWS)) ? RW'(ROWS) : RW'(r_end);

    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_vld;
    assign w_clr      = o_cmd_pop && (i_cmd.op == OP_CLEAR);
    assign w_we       = (r_state == S_UWR);
    assign w_res_push = (r_state == S_RES) && (r_ocnt != 2'd2);
    assign w_res_pop  = i_pop && (r_ocnt != 2'd0);

    // request to the shared arithmetic unit
    always_comb begin
        w_math = 1'b1;
        w_areq = '{start: 1'b0, op: AOP_MUL, a: '0, b: '0};
        case (r_state)
            S_DK:   begin w_areq.a = r_key;  w_areq.b = r_delta; end
            S_HK1:  begin w_areq.a = r_hd;   w_areq.b = C_K1;    end
            S_HK2:  begin w_areq.a = r_ht;   w_areq.b = C_K2;    end
            S_HA1:  begin w_areq.a = r_ha;   w_areq.b = C_M1;    end
            S_HA2:  begin w_areq.a = r_ha;   w_areq.b = C_M2;    end
            S_HB1:  begin w_areq.a = r_hb;   w_areq.b = C_M1;    end
            S_HB2:  begin w_areq.a = r_hb;   w_areq.b = C_M2;    end
            S_RDIV: begin
                w_areq.op = AOP_DIV;
                w_areq.a  = r_un;
                w_areq.b  = r_ud;
            end
            S_FMUL: begin
                w_math    = r_e[0];
                w_areq.op = AOP_MODMUL;
                w_areq.a  = r_pw;
                w_areq.b  = r_base;
            end
            S_FSQ: begin
                w_areq.op = AOP_MODMUL;
                w_areq.a  = r_base;
                w_areq.b  = r_base;
            end
            S_FFIN: begin
                w_areq.op = AOP_MODMUL;
                w_areq.a  = r_cm;
                w_areq.b  = r_pw;
            end
            default: w_math = 1'b0;
        endcase
        w_areq.start = w_math && !r_wait;
    end

    assign o_areq = w_areq;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
        end else begin
            if (w_areq.start) begin
                r_wait <= 1'b1;
            end else if (i_arsp.done) begin
                r_wait <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_vld) begin
                        r_op    <= i_cmd.op;
                        r_key   <= i_cmd.item_key;
                        r_delta <= i_cmd.weight_delta;
                        r_first <= i_cmd.first_row;
                        r_end   <= i_cmd.end_row;
                        r_hd    <= i_seed;
                        r_hs    <= SEED_SALT;
                        r_hret  <= S_SEED;
                        if (i_cmd.op != OP_CLEAR) begin
                            r_state <= S_HK1;
                        end
                    end
                end
                S_SEED: begin
                    r_s     <= r_hres;
                    r_state <= (r_op == OP_UPDATE) ? S_DK : S_RSTART;
                end
                S_DK: begin
                    if (i_arsp.done) begin
                        r_dk    <= w_res;
                        r_row   <= '0;
                        r_h     <= r_s;
                        r_state <= S_ROW;
                    end
                end
                // update: one cell per row
                S_ROW: begin
                    r_hd    <= r_key;
                    r_hs    <= r_h;
                    r_hret  <= S_LEVEL;
                    r_state <= S_HK1;
                end
                S_LEVEL: begin
                    r_h     <= r_hres;
                    r_idx   <= f_idx(r_row, w_lz);
                    r_hd    <= 64'(f_idx(r_row, w_lz));
                    r_hs    <= r_s + 64'd1;
                    r_hret  <= S_UZ;
                    r_state <= S_HK1;
                end
                S_UZ: begin
                    r_base  <= r_hres;
                    r_e     <= r_key;
                    r_c     <= r_delta;
                    r_fret  <= S_UWR;
                    r_state <= S_FZRED;
                end
                S_UWR: begin
                    r_row <= r_row + RW'(1);
                    if (r_row == RW'(ROWS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_ROW;
                    end
                end
                // recover: scan cells of the row range in order
                S_RSTART: begin
                    r_rend <= w_end;
                    r_row  <= RW'(r_first);
                    r_pos  <= '0;
                    if (RW'(r_first) >= w_end) begin
                        r_found <= 1'b0;
                        r_rkey  <= '1;
                        r_state <= S_RES;
                    end else begin
                        r_state <= S_RCELL;
                    end
                end
                S_RCELL: begin
                    r_idx   <= f_idx(r_row, r_pos);
                    r_state <= S_RREAD;
                end
                S_RREAD: r_state <= S_RCHK;
                S_RCHK: begin
                    r_un    <= w_sum[63] ? (64'd0 - w_sum) : w_sum;
                    r_ud    <= w_cnt[63] ? (64'd0 - w_cnt) : w_cnt;
                    r_qneg  <= w_sum[63] ^ w_cnt[63];
                    r_state <= (w_cnt == '0) ? S_RNEXT : S_RDIV;
                end
                S_RDIV: begin
                    if (i_arsp.done) begin
                        r_q     <= r_qneg ? (64'd0 - w_res) : w_res;
                        r_hd    <= 64'(r_idx);
                        r_hs    <= r_s + 64'd1;
                        r_hret  <= S_RZ;
                        r_state <= S_HK1;
                    end
                end
                S_RZ: begin
                    r_base  <= r_hres;
                    r_e     <= r_q;
                    r_c     <= w_cnt;
                    r_fret  <= S_RCMP;
                    r_state <= S_FZRED;
                end
                S_RCMP: begin
                    if ({2'b00, w_fp} == r_term) begin
                        r_found <= 1'b1;
                        r_rkey  <= r_q;
                        r_state <= S_RES;
                    end else begin
                        r_state <= S_RNEXT;
                    end
                end
                S_RNEXT: begin
                    if (r_pos == PW'(CPR - 1)) begin
                        r_pos <= '0;
                        r_row <= r_row + RW'(1);
                        if (r_row + RW'(1) == r_rend) begin
                            r_found <= 1'b0;
                            r_rkey  <= '1;
                            r_state <= S_RES;
                        end else begin
                            r_state <= S_RCELL;
                        end
                    end else begin
                        r_pos   <= r_pos + PW'(1);
                        r_state <= S_RCELL;
                    end
                end
                S_RES: begin
                    if (w_res_push) begin
                        r_state <= S_IDLE;
                    end
                end
                // hash64(r_hd, r_hs) into r_hres
                S_HK1: begin
                    if (i_arsp.done) begin
                        r_ht    <= w_k;
                        r_state <= S_HK2;
                    end
                end
                S_HK2: begin
                    if (i_arsp.done) begin
                        r_ha    <= f_mix(w_a1);
                        r_hb    <= f_mix(w_b1);
                        r_state <= S_HA1;
                    end
                end
                S_HA1: begin
                    if (i_arsp.done) begin
                        r_ha    <= f_mix(w_res);
                        r_state <= S_HA2;
                    end
                end
                S_HA2: begin
                    if (i_arsp.done) begin
                        r_ha    <= f_mix(w_res);
                        r_state <= S_HB1;
                    end
                end
                S_HB1: begin
                    if (i_arsp.done) begin
                        r_hb    <= f_mix(w_res);
                        r_state <= S_HB2;
                    end
                end
                S_HB2: begin
                    if (i_arsp.done) begin
                        r_hres  <= r_ha + f_mix(w_res);
                        r_state <= r_hret;
                    end
                end
                // fingerprint (r_c mod P) * r_base^max(r_e,1) mod P to r_term
                S_FZRED: begin
                    if (r_base >= PRIME) begin
                        r_base <= r_base - PRIME;
                    end else if (r_e[63] || (r_e < 64'd2)) begin
                        r_pw    <= r_base;
                        r_state <= S_FCM;
                    end else begin
                        r_pw    <= 64'd1;
                        r_state <= S_FMUL;
                    end
                end
                S_FMUL: begin
                    if (!r_e[0] || i_arsp.done) begin
                        if (r_e[0]) begin
                            r_pw <= w_res;
                        end
                        r_state <= (r_e[63:1] == '0) ? S_FCM : S_FSQ;
                    end
                end
                S_FSQ: begin
                    if (i_arsp.done) begin
                        r_base  <= w_res;
                        r_e     <= r_e >> 1;
                        r_state <= S_FMUL;
                    end
                end
                S_FCM: begin
                    r_cneg  <= r_c[63];
                    r_cm    <= r_c[63] ? (64'd0 - r_c) : r_c;
                    r_state <= S_FCRED;
                end
                S_FCRED: begin
                    if (r_cm >= PRIME) begin
                        r_cm <= r_cm - PRIME;
                    end else begin
                        if (r_cneg && (r_cm != '0)) begin
                            r_cm <= PRIME - r_cm;
                        end
                        r_state <= S_FFIN;
                    end
                end
                S_FFIN: begin
                    if (i_arsp.done) begin
                        r_term  <= w_res;
                        r_state <= r_fret;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // cell store, read data registered at the current cell address
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_idx] <= {w_cnt + r_delta, w_sum + r_dk, f_add_mod(w_fp, r_term[61:0])};
        end
        r_rd <= r_mem[r_idx];
    end

    // per-cell valid bits, cleared by reset and by a clear item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clr) begin
            for (int i = 0; i < NCELLS; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_rdv <= 1'b0;
        end else begin
            if (w_we) begin
                r_vld[r_idx] <= 1'b1;
            end
            r_rdv <= r_vld[r_idx];
        end
    end

    // two-entry result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= '0;
        end else begin
            if (w_res_push) begin
                r_oq[r_owp] <= '{found: r_found, recovered_key: r_rkey};
                r_owp       <= !r_owp;
            end
            if (w_res_pop) begin
                r_orp <= !r_orp;
            end
            r_ocnt <= r_ocnt + {1'b0, w_res_push} - {1'b0, w_res_pop};
        end
    end

    assign o_res   = r_oq[r_orp];
    assign o_empty = (r_ocnt == 2'd0);

    `ASSERT_IMP(a_rsp_issued, i_arsp.done, r_wait)
    `ASSERT_IMP(a_res_recover, w_res_push, r_op == OP_RECOVER)

endmodule

// File: src/l0_sampling_sketch.sv
// L0 sampler sketch over 8 rows of 32 cells (count, key sum, fingerprint mod 2^62-57).
// Input queue: drive i_item and push; the item is taken when full is low.
//   op update adds the item to one cell per row, op recover scans rows
//   [first_row, end_row) for a single-key cell, op clear empties the store.
// Result queue: recover leaves one item (found, recovered_key) at the head
//   while empty is low; pop takes it. Update, clear and op code 3 leave none.
// Seed: write i_cfg_data with i_cfg_valid (always ready) while the block is idle.
// Queues: two commands queue up ahead of the engine and two results behind it,
//   so a stalled reader holds the engine only when the result queue is full.
//   All multiplies and divides run on one shared unit: 64-bit multiply, modular
//   multiply and divide. Update time grows with ROWS and with popcount(key) +
//   bitlength(key). Recover time grows with each scanned cell: a cell whose
//   count is zero is passed without arithmetic, else the cost grows with
//   popcount(q) + bitlength(q) with q = sum/count. Clear takes effect as the
//   item leaves the command queue.
// Reset: synchronous, active low; seed goes to zero and every cell reads zero.
module l0_sampling_sketch (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  lss_pkg::t_in  i_item,
    output logic          empty,
    input  logic          pop,
    output lss_pkg::t_out o_res,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [63:0]   i_cfg_data
);
    import lss_pkg::*;

    t_in         w_cmd;
    logic        w_cmd_vld, w_cmd_pop;
    logic [63:0] w_seed;
    t_areq       w_areq;
    t_arsp       w_arsp;

    // front: seed register, classify and command queue
    lss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_seed      (w_seed),
        .o_cmd       (w_cmd),
        .o_cmd_vld   (w_cmd_vld),
        .i_cmd_pop   (w_cmd_pop)
    );

    // back: sequencer, cell store and result queue
    lss_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_cmd_vld (w_cmd_vld),
        .o_cmd_pop (w_cmd_pop),
        .i_seed    (w_seed),
        .o_areq    (w_areq),
        .i_arsp    (w_arsp),
        .o_res     (o_res),
        .o_empty   (empty),
        .i_pop     (pop)
    );

    // shared iterative arithmetic
    lss_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_areq),
        .o_rsp   (w_arsp)
    );

endmodule

// File: tb/testbench.sv
module testbench;
    import lss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCH_LIMIT = 10000000;
    localparam int DRAIN_CYCLES = 200;

    logic i_clk;
    logic i_rst_n;
    logic push;
    logic full;
    t_in  i_item;
    logic empty;
    logic pop;
    t_out o_res;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [63:0] i_cfg_data;

    l0_sampling_sketch u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_res      (o_res),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state
    logic [63:0] seed_reg;
    logic [63:0] cnt_store [NCELLS];
    logic [63:0] sum_store [NCELLS];
    logic [61:0] fp_store  [NCELLS];

    t_in  pending_items[$];
    t_out expected_keys[$];
    int   error_count;
    int   items_sent;
    int   results_seen;
    int   found_seen;
    bit   idle_enable;
    int   watch_count;

    // hash and modular arithmetic
    function automatic logic [63:0] mix_bits(input logic [63:0] v);
        logic [63:0] k;
        k = v;
        k = k ^ (k >> SHR_M);
        k = k * C_M1;
        k = k ^ (k >> SHR_M);
        k = k * C_M2;
        k = k ^ (k >> SHR_M);
        return k;
    endfunction

    function automatic logic [63:0] hash_key(input logic [63:0] d, input logic [63:0] s);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] k;
        a = s;
        b = s;
        k = d * C_K1;
        k = (k << ROT_K) | (k >> (64 - ROT_K));
        k = k * C_K2;
        a = a ^ k;
        a = a ^ 64'd8;
        b = b ^ 64'd8;
        a = a + b;
        b = b + a;
        return mix_bits(a) + mix_bits(b);
    endfunction

    function automatic logic [63:0] modmul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = a * b;
        return 64'(p % {64'd0, PRIME});
    endfunction

    function automatic logic [61:0] weighted_power(input logic [63:0] c, input logic [63:0] z,
                                                   input logic [63:0] e);
        logic [63:0] base;
        logic [63:0] pw;
        logic [63:0] ex;
        logic [63:0] cm;
        logic [63:0] m;
        base = z % PRIME;
        ex = e;
        if (ex[63] || ex < 2) begin
            pw = base;
        end else begin
            pw = 1;
            while (ex != 0) begin
                if (ex[0]) pw = modmul(pw, base);
                base = modmul(base, base);
                ex = ex >> 1;
            end
        end
        if (c[63]) begin
            m = (-c) % PRIME;
            cm = (m != 0) ? PRIME - m : 0;
        end else begin
            cm = c % PRIME;
        end
        return 62'(modmul(cm, pw));
    endfunction

    function automatic logic [63:0] trunc_div(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] un;
        logic [63:0] ud;
        logic [63:0] q;
        un = n[63] ? -n : n;
        ud = d[63] ? -d : d;
        q = un / ud;
        return (n[63] != d[63]) ? -q : q;
    endfunction

    // model one accepted item, queue a result for recover
    task automatic apply_sketch_item(input t_in it);
        logic [63:0] s;
        logic [63:0] h;
        logic [31:0] v;
        logic [63:0] q;
        logic [63:0] e;
        t_out r;
        int pos;
        int idx;
        int last;
        bit hit;
        s = hash_key(seed_reg, SEED_SALT);
        if (it.op == OP_UPDATE) begin
            h = s;
            for (int j = 0; j < ROWS; j++) begin
                h = hash_key(it.item_key, h);
                v = h[31:0];
                if (v == 0) v = 1;
                pos = 0;
                while (!v[CPR - 1 - pos]) pos++;
                idx = j * CPR + pos;
                cnt_store[idx] = cnt_store[idx] + it.weight_delta;
                e = it.weight_delta * it.item_key;
                sum_store[idx] = sum_store[idx] + e;
                fp_store[idx] = f_add_mod(fp_store[idx], weighted_power(it.weight_delta,
                    hash_key(64'(idx), s + 1), it.item_key));
            end
        end else if (it.op == OP_RECOVER) begin
            last = (it.end_row > ROWS) ? ROWS : it.end_row;
            hit = 0;
            r.found = 0;
            r.recovered_key = '1;
            for (int rr = it.first_row; rr < last && !hit; rr++) begin
                for (int c = 0; c < CPR && !hit; c++) begin
                    idx = rr * CPR + c;
                    if (cnt_store[idx] != 0) begin
                        q = trunc_div(sum_store[idx], cnt_store[idx]);
                        if (fp_store[idx] == weighted_power(cnt_store[idx],
                                hash_key(64'(idx), s + 1), q)) begin
                            hit = 1;
                            r.found = 1;
                            r.recovered_key = q;
                        end
                    end
                end
            end
            expected_keys.push_back(r);
        end else if (it.op == OP_CLEAR) begin
            for (int i = 0; i < NCELLS; i++) begin
                cnt_store[i] = 0;
                sum_store[i] = 0;
                fp_store[i] = 0;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // clock
    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // sender: one item per handshake, random idle bursts
    int send_gap;
    bit item_taken;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 0;
            send_gap <= 0;
        end else if (push && !item_taken) begin
            // hold the item until it is taken
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            push <= 0;
        end else if (pending_items.size() != 0) begin
            if (idle_enable && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(1, 7) - 1;
                push <= 0;
            end else begin
                i_item <= pending_items[0];
                push <= 1;
            end
        end else begin
            push <= 0;
        end
    end

    // accepted items go through the predictor at the rising edge
    always @(posedge i_clk) begin
        item_taken = i_rst_n && push && !full;
        if (item_taken) begin
            apply_sketch_item(i_item);
            void'(pending_items.pop_front());
            items_sent++;
        end
    end

    // receiver stalls
    int recv_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 0;
            recv_gap <= 0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            pop <= 0;
        end else if (idle_enable && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(1, 7) - 1;
            pop <= 0;
        end else begin
            pop <= 1;
        end
    end

    // result check
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && pop && !empty) begin
            results_seen++;
            if (expected_keys.size() == 0) begin
                report_mismatch("unexpected result", o_res.recovered_key, 0);
            end else begin
                want = expected_keys.pop_front();
                if (want.found) found_seen++;
                if (o_res.found !== want.found)
                    report_mismatch("found", 64'(o_res.found), 64'(want.found));
                if (o_res.recovered_key !== want.recovered_key)
                    report_mismatch("recovered_key", o_res.recovered_key,
                                    want.recovered_key);
            end
        end
    end

    // watchdog on accepted handshakes
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            watch_count <= 0;
        end else begin
            watch_count <= watch_count + 1;
            if (watch_count == WATCH_LIMIT) begin
                $display("timeout with %0d results still expected", expected_keys.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // small key so the exponentiation stays short
    function automatic logic [63:0] short_key();
        int w;
        w = $urandom_range(1, 12);
        return $urandom_range(0, 1) ? -64'($urandom_range(0, (1 << w) - 1))
                                    : 64'($urandom_range(0, (1 << w) - 1));
    endfunction

    function automatic t_in make_item(input t_op op, input logic [63:0] key,
                                      input logic [63:0] delta, input int f, input int e);
        t_in it;
        it.op = op;
        it.item_key = key;
        it.weight_delta = delta;
        it.first_row = 4'(f);
        it.end_row = 4'(e);
        return it;
    endfunction

    // an empty-range recover behind the last item marks when the engine is done
    task automatic wait_idle();
        pending_items.push_back(make_item(OP_RECOVER, 0, 0, 0, 0));
        while (pending_items.size() != 0 || push || expected_keys.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // seed write at a quiet point
    task automatic write_seed(input logic [63:0] val);
        wait_idle();
        @(negedge i_clk);
        i_cfg_data <= val;
        i_cfg_valid <= 1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        seed_reg = val;
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    // stimulus
    initial begin
        logic [63:0] k;
        logic [63:0] d;
        int f;
        int n;
        error_count = 0;
        items_sent = 0;
        results_seen = 0;
        found_seen = 0;
        idle_enable = 1;
        watch_count = 0;
        seed_reg = 0;
        for (int i = 0; i < NCELLS; i++) begin
            cnt_store[i] = 0;
            sum_store[i] = 0;
            fp_store[i] = 0;
        end
        i_rst_n = 0;
        push = 0;
        pop = 0;
        i_item = '0;
        i_cfg_valid = 0;
        i_cfg_data = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: empty store, row range edges, singletons, extremes
        pending_items.push_back(make_item(OP_RECOVER, 0, 0, 0, 8));
        pending_items.push_back(make_item(OP_UPDATE, 64'sd5, 64'sd1, 0, 0));
        pending_items.push_back(make_item(OP_RECOVER, 0, 0, 0, 8));
        pending_items.push_back(make_item(OP_RECOVER, 0, 0, 0, 15));
        pending_items.push_back(make_item(OP_RECOVER, 0, 0, 5, 5));
        pending_items.push_back(make_item(OP_RECOVER, 0, 0, 15, 2));
        pending_items.push_back(make_item(OP_UPDATE, 64'sd5, -64'sd1, 0, 0));
        pending_items.push_back(make_item(OP_RECOVER, 0, 0, 0, 8));
        pending_items.push_back(make_item(OP_UPDATE, -64'sd7, 64'sd3, 0, 0));
        pending_items.push_back(make_item(OP_UPDATE, 64'sd1, 64'h7fffffffffffffff, 0, 0));
        pending_items.push_back(make_item(OP_RECOVER, 0, 0, 0, 8));
        pending_items.push_back(make_item(OP_NOP, '1, '1, 15, 15));
        pending_items.push_back(make_item(OP_CLEAR, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_UPDATE, 64'h8000000000000000, -64'sd1, 0, 0));
        pending_items.push_back(make_item(OP_RECOVER, 0, 0, 0, 8));
        pending_items.push_back(make_item(OP_UPDATE, 64'h7fffffffffffffff,
                                          64'h8000000000000000, 0, 0));
        pending_items.push_back(make_item(OP_RECOVER, 0, 0, 3, 8));
        pending_items.push_back(make_item(OP_UPDATE, 0, 64'sd2, 0, 0));
        pending_items.push_back(make_item(OP_RECOVER, 0, 0, 0, 1));
        pending_items.push_back(make_item(OP_CLEAR, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_RECOVER, 0, 0, 0, 8));

        // stimulus waits until all results are in
        wait_idle();

        // random phases over several seeds, extremes first
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_seed('1);
                1: write_seed(0);
                default: write_seed(rand64());
            endcase
            if (ph == 4) idle_enable = 0;
            pending_items.push_back(make_item(OP_CLEAR, 0, 0, 0, 0));
            n = 0;
            while (n < 106) begin
                f = $urandom_range(0, 99);
                if (f < 55) begin
                    // mostly small keys, a few full-width ones
                    k = ($urandom_range(0, 19) == 0) ? rand64() : short_key();
                    d = ($urandom_range(0, 9) == 0) ? rand64()
                        : 64'($signed($urandom_range(0, 6)) - 3);
                    pending_items.push_back(make_item(OP_UPDATE, k, d, 0, 0));
                end else if (f < 92) begin
                    pending_items.push_back(make_item(OP_RECOVER, 0, 0,
                        $urandom_range(0, 15), $urandom_range(0, 15)));
                end else if (f < 96) begin
                    pending_items.push_back(make_item(OP_CLEAR, 0, 0, 0, 0));
                end else begin
                    pending_items.push_back(make_item(OP_NOP, rand64(), rand64(),
                        $urandom_range(0, 15), $urandom_range(0, 15)));
                    n--;
                end
                n++;
                while (pending_items.size() > 4) @(posedge i_clk);
            end
        end

        wait_idle();
        $display("sent %0d items, checked %0d recover results (%0d found)",
                 items_sent, results_seen, found_seen);
        $display("covered five seeds including all-zero and all-one, row range edges, clears");
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/lss_pkg.sv
src/lss_front.sv
src/lss_arith.sv
src/lss_back.sv
src/l0_sampling_sketch.sv
tb/testbench.sv
